[design/mcr_pkg.sv]
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer package
// Shared types and constants for the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package mcr_pkg;

  // Widths fixed by the result fields.
  localparam int unsigned XW    = 9;
  localparam int unsigned YW    = 8;
  // Working width of coordinate sums and bound compares.
  localparam int unsigned WIDEW = 10;

  // A walk never emits more than this many results.
  localparam int unsigned ResultLimit = 64;
  localparam int unsigned CountW      = $clog2(ResultLimit);

  // Configuration registers.
  localparam int unsigned WidthW  = 8;
  localparam int unsigned HeightW = 7;
  localparam logic [WidthW-1:0]  WidthReset  = 8'd128;
  localparam logic [HeightW-1:0] HeightReset = 7'd64;

  typedef enum logic {
    RegWidth  = 1'b0,
    RegHeight = 1'b1
  } reg_idx_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;  // capture a new circle request
    logic step;  // emit one result and advance the walk
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
    logic last;      // the result being computed ends the walk
  } status_t;

endpackage

[design/midpoint_circle_rasterizer_unit.sv]
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer unit
// Walks one quadrant of a circle and emits four mirrored pixels per step.
// ----------------------------------------------------------------------------
// Usage: a request carries a circle center and radius on the input channel
// (in_valid_i / in_ready_o). The unit takes one request at a time; in_ready_o
// is high only while no walk is in progress. Each step of the walk leaves on
// the output channel (out_valid_o / out_ready_i) as one result holding the four
// mirrored points, an on-screen mask and a last-step flag.
// A request is captured first; its first step then fills the result register.
// Throughput: one result per cycle while the receiver keeps out_ready_i high;
// a radius R walk yields at most 2R+1 results, one per decision-term step.
// Radii above MAX_RADIUS are saturated to it; a walk is capped at 64 results.
// When the receiver stalls, the result register holds and the walk pauses.
// Reset clears the controller to idle, drops any pending result and restores
// the display size registers to 128 columns by 64 rows.
// The APB port holds display_width at byte 0 and display_height at byte 4;
// the user must write it only while the unit is idle; the unit does not enforce this.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit #(
  parameter int unsigned MAX_RADIUS = 31
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB-style configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [6:0]                    center_x_i,
  input  logic [5:0]                    center_y_i,
  input  logic [4:0]                    radius_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [mcr_pkg::XW-1:0] px_a_x_o,
  output logic signed [mcr_pkg::YW-1:0] px_a_y_o,
  output logic signed [mcr_pkg::XW-1:0] px_b_x_o,
  output logic signed [mcr_pkg::YW-1:0] px_b_y_o,
  output logic signed [mcr_pkg::XW-1:0] px_c_x_o,
  output logic signed [mcr_pkg::YW-1:0] px_c_y_o,
  output logic signed [mcr_pkg::XW-1:0] px_d_x_o,
  output logic signed [mcr_pkg::YW-1:0] px_d_y_o,
  output logic [3:0]                    on_screen_o,
  output logic                          last_step_o
);

  // Display size registers. Address bit 2 selects the register; values are
  // used as written, so a zero size puts nothing on screen along that axis.
  logic [mcr_pkg::WidthW-1:0]  width_q;
  logic [mcr_pkg::HeightW-1:0] height_q;
  logic                        wr_en;
  mcr_pkg::reg_idx_e           reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = mcr_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mcr_pkg::WidthReset;
      height_q <= mcr_pkg::HeightReset;
    end else if (wr_en) begin
      case (reg_idx)
        mcr_pkg::RegWidth:  width_q  <= pwdata[mcr_pkg::WidthW-1:0];
        mcr_pkg::RegHeight: height_q <= pwdata[mcr_pkg::HeightW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mcr_pkg::RegWidth:  prdata = 32'(width_q);
      mcr_pkg::RegHeight: prdata = 32'(height_q);
      default:            prdata = '0;
    endcase
  end

  // The controller only issues load and step commands; all arithmetic sits
  // in the datapath, which reports back whether its result slot is free and
  // whether the step in flight ends the walk.
  mcr_pkg::cmd_t    cmd;
  mcr_pkg::status_t status;

  mcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mcr_datapath #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_i    (radius_i),
    .width_i     (width_q),
    .height_i    (height_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .px_a_x_o    (px_a_x_o),
    .px_a_y_o    (px_a_y_o),
    .px_b_x_o    (px_b_x_o),
    .px_b_y_o    (px_b_y_o),
    .px_c_x_o    (px_c_x_o),
    .px_c_y_o    (px_c_y_o),
    .px_d_x_o    (px_d_x_o),
    .px_d_y_o    (px_d_y_o),
    .on_screen_o (on_screen_o),
    .last_step_o (last_step_o)
  );

endmodule

[design/mcr_ctrl.sv]
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer controller
// Sequences one circle request at a time: capture, then one step per free slot.
// ----------------------------------------------------------------------------
module mcr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mcr_pkg::status_t status_i,
  output mcr_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StWalk = 2'b10
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);
  assign cmd_o.load = in_valid_i && (state_q == StIdle);
  assign cmd_o.step = (state_q == StWalk) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.load) state_d = StWalk;
      end
      StWalk: begin
        if (cmd_o.step && status_i.last) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/mcr_datapath.sv]
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer datapath
// Offset and decision registers, the step update, bound tests and result register.
// ----------------------------------------------------------------------------
module mcr_datapath #(
  parameter int unsigned MAX_RADIUS = 31
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mcr_pkg::cmd_t                      cmd_i,
  output mcr_pkg::status_t                   status_o,
  input  logic [6:0]                         center_x_i,
  input  logic [5:0]                         center_y_i,
  input  logic [4:0]                         radius_i,
  input  logic [mcr_pkg::WidthW-1:0]         width_i,
  input  logic [mcr_pkg::HeightW-1:0]        height_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mcr_pkg::XW-1:0]      px_a_x_o,
  output logic signed [mcr_pkg::YW-1:0]      px_a_y_o,
  output logic signed [mcr_pkg::XW-1:0]      px_b_x_o,
  output logic signed [mcr_pkg::YW-1:0]      px_b_y_o,
  output logic signed [mcr_pkg::XW-1:0]      px_c_x_o,
  output logic signed [mcr_pkg::YW-1:0]      px_c_y_o,
  output logic signed [mcr_pkg::XW-1:0]      px_d_x_o,
  output logic signed [mcr_pkg::YW-1:0]      px_d_y_o,
  output logic [3:0]                         on_screen_o,
  output logic                               last_step_o
);

  localparam int unsigned RW = $clog2(MAX_RADIUS + 1);
  localparam int unsigned OW = RW + 2;   // signed offsets, dy may reach -1
  localparam int unsigned DW = RW + 4;   // signed decision term
  localparam int unsigned WW = mcr_pkg::WIDEW;
  localparam int unsigned CW = mcr_pkg::CountW;

  logic [6:0]             cx_q;
  logic [5:0]             cy_q;
  logic signed [OW-1:0]   dx_q, dx_d;
  logic signed [OW-1:0]   dy_q, dy_d;
  logic signed [DW-1:0]   d_q, d_d;
  logic [CW-1:0]          cnt_q;
  logic                   valid_q;

  // Radius saturation.
  logic [6:0]             r_wide;
  logic [RW-1:0]          r_sat;
  assign r_wide = ({2'b00, radius_i} > 7'(MAX_RADIUS)) ? 7'(MAX_RADIUS) : {2'b00, radius_i};
  assign r_sat  = r_wide[RW-1:0];

  // Decision: grow dx only, shrink dy only, or move diagonally.
  logic signed [DW-1:0] dx_w, dy_w, sum_dy, dif_dx;
  logic                 grow_x, shrink_y;
  assign dx_w     = DW'(dx_q);
  assign dy_w     = DW'(dy_q);
  assign sum_dy   = d_q + dy_w;
  assign dif_dx   = d_q - dx_w;
  assign grow_x   = (d_q < 0) && (sum_dy <= 0);
  assign shrink_y = (d_q > 0) && (dif_dx > 0);

  always_comb begin
    if (grow_x) begin
      dx_d = dx_q + OW'(1);
      dy_d = dy_q;
      d_d  = d_q + (dx_w <<< 1) + DW'(3);
    end else if (shrink_y) begin
      dx_d = dx_q;
      dy_d = dy_q - OW'(1);
      d_d  = d_q + DW'(3) - (dy_w <<< 1);
    end else begin
      dx_d = dx_q + OW'(1);
      dy_d = dy_q - OW'(1);
      d_d  = d_q + ((dx_w - dy_w) <<< 1) + DW'(2);
    end
  end

  assign status_o.last     = (dy_d < 0) || (cnt_q == CW'(mcr_pkg::ResultLimit - 1));
  assign status_o.out_free = !valid_q || out_ready_i;

  // Mirrored coordinates and bound tests.
  logic signed [WW-1:0] cx_w, cy_w, ox_w, oy_w, xp, xm, yp, ym, wd_w, ht_w;
  assign cx_w = $signed(WW'(cx_q));
  assign cy_w = $signed(WW'(cy_q));
  assign ox_w = WW'(dx_q);
  assign oy_w = WW'(dy_q);
  assign xp   = cx_w + ox_w;
  assign xm   = cx_w - ox_w;
  assign yp   = cy_w + oy_w;
  assign ym   = cy_w - oy_w;
  assign wd_w = $signed(WW'(width_i));
  assign ht_w = $signed(WW'(height_i));

  logic xp_in, xm_in, yp_in, ym_in;
  assign xp_in = (xp >= 0) && (xp < wd_w);
  assign xm_in = (xm >= 0) && (xm < wd_w);
  assign yp_in = (yp >= 0) && (yp < ht_w);
  assign ym_in = (ym >= 0) && (ym < ht_w);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q  <= center_x_i;
      cy_q  <= center_y_i;
      dx_q  <= '0;
      dy_q  <= OW'(r_sat);
      d_q   <= DW'(1) - (DW'(r_sat) <<< 1);
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      d_q   <= d_d;
      cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      px_a_x_o    <= xp[mcr_pkg::XW-1:0];
      px_a_y_o    <= yp[mcr_pkg::YW-1:0];
      px_b_x_o    <= xp[mcr_pkg::XW-1:0];
      px_b_y_o    <= ym[mcr_pkg::YW-1:0];
      px_c_x_o    <= xm[mcr_pkg::XW-1:0];
      px_c_y_o    <= yp[mcr_pkg::YW-1:0];
      px_d_x_o    <= xm[mcr_pkg::XW-1:0];
      px_d_y_o    <= ym[mcr_pkg::YW-1:0];
      on_screen_o <= {xm_in && ym_in, xm_in && yp_in, xp_in && ym_in, xp_in && yp_in};
      last_step_o <= status_o.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;

endmodule
